/* src/rfc_pkg.sv */
// Shared types and constants of the reply frame checker.
package rfc_pkg;

  localparam int unsigned POS_W = 17;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [2:0]       verdict_t;

  localparam verdict_t VERDICT_BUSY      = 3'd0;
  localparam verdict_t VERDICT_OK        = 3'd1;
  localparam verdict_t VERDICT_BAD_SYNC  = 3'd2;
  localparam verdict_t VERDICT_CHECKSUM  = 3'd3;
  localparam verdict_t VERDICT_TOO_SHORT = 3'd4;

  localparam byte_t SYNC_RESET = 8'h7E;
  localparam byte_t XOR_INIT   = 8'hFF;
  localparam pos_t  STATUS_POS = 17'd5;
  localparam pos_t  MIN_TOTAL  = 17'd6;
  localparam pos_t  FIRST_SUM  = 17'd4;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

endpackage

/* src/rfc_if.sv */
// Stream interfaces for received bytes and per-byte check results.
interface rfc_rx_if;
  logic          valid;
  logic          ready;
  rfc_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfc_res_if;
  logic              valid;
  logic              ready;
  rfc_pkg::byte_t    data_byte;
  rfc_pkg::pos_t     byte_position;
  logic              frame_end;
  rfc_pkg::verdict_t verdict;
  rfc_pkg::byte_t    status_code;

  modport source (output valid, output data_byte, output byte_position, output frame_end,
                  output verdict, output status_code, input ready);
  modport sink   (input valid, input data_byte, input byte_position, input frame_end,
                  input verdict, input status_code, output ready);
endinterface

/* src/reply_frame_checker.sv */
// Reply frame checker top level: register block and per-byte frame checker.
// Each accepted byte gives one result, held in the result register from the cycle after it is accepted.
// A new byte is accepted every cycle while the result register is empty or being taken.
// Synchronous reset returns the checker to hunting for sync and empties the result register.
// Reset also sets the sync byte register to 0x7E.
module reply_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfc_pkg::ADDR_W-1:0] paddr,
  input  logic [rfc_pkg::DATA_W-1:0] pwdata,
  output logic [rfc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  rfc_rx_if.sink                     rx,
  rfc_res_if.source                  res
);
  import rfc_pkg::*;

  byte_t sync_byte;

  rfc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sync_byte (sync_byte)
  );

  rfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .rx        (rx),
    .res       (res)
  );

endmodule

/* src/rfc_regs.sv */
// APB register block holding the sync byte.
module rfc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rfc_pkg::DATA_W-1:0]   pwdata,
  output logic [rfc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rfc_pkg::byte_t               sync_byte
);
  import rfc_pkg::*;

  logic sel_sync;

  assign pready   = 1'b1;
  assign sel_sync = (paddr[ADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (psel && penable && pwrite && sel_sync) begin
      sync_byte <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_sync) begin
      prdata = {{(DATA_W-8){1'b0}}, sync_byte};
    end
  end

endmodule

/* src/rfc_core.sv */
// Frame state, per-byte checks and the result register.
module rfc_core (
  input  logic           clk,
  input  logic           rst,
  input  rfc_pkg::byte_t sync_byte,
  rfc_rx_if.sink         rx,
  rfc_res_if.source      res
);
  import rfc_pkg::*;

  logic     in_frame, in_frame_next;
  pos_t     position, position_next;
  pos_t     frame_total, frame_total_next;
  byte_t    running_xor, running_xor_next;
  byte_t    running_sum, running_sum_next;
  logic     xor_matched, xor_matched_next;
  byte_t    status_hold, status_hold_next;

  pos_t     res_pos;
  logic     res_end;
  verdict_t res_verdict;
  byte_t    res_status;

  logic     out_valid;
  byte_t    out_data;
  pos_t     out_pos;
  logic     out_end;
  verdict_t out_verdict;
  byte_t    out_status;

  logic          accept;
  logic [POS_W:0] pos_ext, pos_p1, pos_p2, pos_p3, total_ext, total_raw;
  logic          in_window;
  byte_t         want_sum;

  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign pos_ext   = {1'b0, position};
  assign total_ext = {1'b0, frame_total};
  assign pos_p1    = pos_ext + 18'd1;
  assign pos_p2    = pos_ext + 18'd2;
  assign pos_p3    = pos_ext + 18'd3;
  assign total_raw = {1'b0, frame_total | {9'd0, rx.rx_byte}} + 18'd2;
  assign in_window = (position >= FIRST_SUM) && (pos_p3 <= total_ext);
  assign want_sum  = running_sum + running_xor;

  always_comb begin
    in_frame_next    = in_frame;
    position_next    = position;
    frame_total_next = frame_total;
    running_xor_next = running_xor;
    running_sum_next = running_sum;
    xor_matched_next = xor_matched;
    status_hold_next = status_hold;
    res_pos          = '0;
    res_end          = 1'b0;
    res_verdict      = VERDICT_BUSY;
    res_status       = '0;

    if (!in_frame) begin
      if (rx.rx_byte == sync_byte) begin
        in_frame_next    = 1'b1;
        position_next    = 17'd1;
        frame_total_next = '0;
        running_xor_next = XOR_INIT;
        running_sum_next = '0;
        xor_matched_next = 1'b0;
        status_hold_next = '0;
      end else begin
        res_end     = 1'b1;
        res_verdict = VERDICT_BAD_SYNC;
      end
    end else begin
      res_pos = position;
      if (position == 17'd1) begin
        frame_total_next = {1'b0, rx.rx_byte, 8'd0};
      end else if (position == 17'd2) begin
        frame_total_next = total_raw[POS_W-1:0];
        if (total_raw[POS_W-1:0] < MIN_TOTAL) begin
          res_end     = 1'b1;
          res_verdict = VERDICT_TOO_SHORT;
        end
      end else begin
        if (position == STATUS_POS) begin
          status_hold_next = rx.rx_byte;
        end
        if (in_window) begin
          running_xor_next = running_xor ^ rx.rx_byte;
          running_sum_next = running_sum + rx.rx_byte;
        end else if (pos_p2 == total_ext) begin
          xor_matched_next = (rx.rx_byte == running_xor);
        end else if (pos_p1 == total_ext) begin
          res_end     = 1'b1;
          res_verdict = (xor_matched && (rx.rx_byte == want_sum)) ?
                        VERDICT_OK : VERDICT_CHECKSUM;
          res_status  = status_hold_next;
        end
      end
      if (res_end) begin
        in_frame_next    = 1'b0;
        position_next    = '0;
        frame_total_next = '0;
        running_xor_next = XOR_INIT;
        running_sum_next = '0;
        xor_matched_next = 1'b0;
        status_hold_next = '0;
      end else begin
        position_next = pos_p1[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      position    <= '0;
      frame_total <= '0;
      running_xor <= XOR_INIT;
      running_sum <= '0;
      xor_matched <= 1'b0;
      status_hold <= '0;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      position    <= position_next;
      frame_total <= frame_total_next;
      running_xor <= running_xor_next;
      running_sum <= running_sum_next;
      xor_matched <= xor_matched_next;
      status_hold <= status_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data    <= rx.rx_byte;
      out_pos     <= res_pos;
      out_end     <= res_end;
      out_verdict <= res_verdict;
      out_status  <= res_status;
    end
  end

  assign res.valid         = out_valid;
  assign res.data_byte     = out_data;
  assign res.byte_position = out_pos;
  assign res.frame_end     = out_end;
  assign res.verdict       = out_verdict;
  assign res.status_code   = out_status;

endmodule

/* tb/reply_frame_checker_test.sv */
// Self-checking testbench of the reply frame checker: directed table, random frames, sync settings.
module reply_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  typedef struct packed {
    byte_t    data;
    pos_t     pos;
    logic     fin;
    verdict_t verdict;
    byte_t    status;
  } result_t;

  typedef struct packed {
    byte_t   value;
    logic    typed;
    result_t want;
  } stim_row_t;

  typedef enum {FRAME_GOOD, FRAME_BAD_XOR, FRAME_BAD_SUM, FRAME_CUT} frame_kind_t;

  localparam logic [ADDR_W-1:0] SYNC_ADDR = '0;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 200;
  localparam int NUM_PHASES = 6;
  localparam result_t UNTYPED = '0;

  localparam stim_row_t DIRECTED [26] = '{
    '{8'h00, 1'b1, '{8'h00, 17'd0, 1'b1, VERDICT_BAD_SYNC, 8'h00}},
    '{8'hFF, 1'b1, '{8'hFF, 17'd0, 1'b1, VERDICT_BAD_SYNC, 8'h00}},
    '{8'h7E, 1'b1, '{8'h7E, 17'd0, 1'b0, VERDICT_BUSY, 8'h00}},
    '{8'h00, 1'b1, '{8'h00, 17'd1, 1'b0, VERDICT_BUSY, 8'h00}},
    '{8'h03, 1'b1, '{8'h03, 17'd2, 1'b1, VERDICT_TOO_SHORT, 8'h00}},
    '{8'h7E, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED},
    '{8'h04, 1'b0, UNTYPED},
    '{8'hA5, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, UNTYPED},
    '{8'hFF, 1'b1, '{8'hFF, 17'd5, 1'b1, VERDICT_OK, 8'hFF}},
    '{8'h7E, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED},
    '{8'h05, 1'b0, UNTYPED},
    '{8'h01, 1'b0, UNTYPED},
    '{8'h80, 1'b0, UNTYPED},
    '{8'h7F, 1'b0, UNTYPED},
    '{8'h00, 1'b1, '{8'h00, 17'd6, 1'b1, VERDICT_CHECKSUM, 8'h7F}},
    '{8'h7E, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED},
    '{8'h06, 1'b0, UNTYPED},
    '{8'h5A, 1'b0, UNTYPED},
    '{8'h12, 1'b0, UNTYPED},
    '{8'h34, 1'b0, UNTYPED},
    '{8'hD9, 1'b0, UNTYPED},
    '{8'h1F, 1'b0, UNTYPED}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rfc_rx_if  rx ();
  rfc_res_if res ();

  reply_frame_checker uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx),
    .res     (res)
  );

  // Mirror of the checker state and its sync register.
  byte_t sync_cfg;
  bit    framing;
  pos_t  cur_pos;
  pos_t  total;
  byte_t run_xor;
  byte_t run_sum;
  bit    xor_ok;
  byte_t status_keep;

  result_t pending_results [$];
  int      errors;
  int      sent_bytes;
  bit      steady;
  bit      hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void queue_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void clear_frame();
    framing     = 1'b0;
    cur_pos     = '0;
    total       = '0;
    run_xor     = XOR_INIT;
    run_sum     = '0;
    xor_ok      = 1'b0;
    status_keep = '0;
  endfunction

  function automatic result_t check_frame_byte(input byte_t b);
    result_t r;
    byte_t   want_sum;
    r = '0;
    r.data = b;
    r.verdict = VERDICT_BUSY;
    if (!framing) begin
      if (b == sync_cfg) begin
        clear_frame();
        framing = 1'b1;
        cur_pos = 17'd1;
      end else begin
        r.fin = 1'b1;
        r.verdict = VERDICT_BAD_SYNC;
      end
    end else begin
      r.pos = cur_pos;
      if (cur_pos == 17'd1) begin
        total = {1'b0, b, 8'h00};
      end else if (cur_pos == 17'd2) begin
        total = total + pos_t'(b) + 17'd2;
        if (total < MIN_TOTAL) begin
          r.fin = 1'b1;
          r.verdict = VERDICT_TOO_SHORT;
        end
      end else begin
        if (cur_pos == STATUS_POS) status_keep = b;
        if (cur_pos >= FIRST_SUM && int'(cur_pos) + 3 <= int'(total)) begin
          run_xor = run_xor ^ b;
          run_sum = run_sum + b;
        end else if (int'(cur_pos) + 2 == int'(total)) begin
          xor_ok = (b == run_xor);
        end else if (int'(cur_pos) + 1 == int'(total)) begin
          want_sum = run_sum + run_xor;
          r.fin = 1'b1;
          r.verdict = (xor_ok && b == want_sum) ? VERDICT_OK : VERDICT_CHECKSUM;
          r.status = status_keep;
        end
      end
      if (r.fin) clear_frame();
      else cur_pos = cur_pos + 17'd1;
    end
    return r;
  endfunction

  function automatic bit sender_rests();
    return !steady && $urandom_range(99) < 26;
  endfunction

  // Called at a rising edge; returns at the edge where the byte is taken.
  task automatic offer_byte(input byte_t b, output result_t predicted);
    while (sender_rests()) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    sent_bytes++;
    predicted = check_frame_byte(b);
  endtask

  task automatic send_byte(input byte_t b);
    result_t predicted;
    offer_byte(b, predicted);
    queue_result(predicted);
  endtask

  task automatic send_frame(input int unsigned len, input frame_kind_t kind);
    byte_t       x;
    byte_t       s;
    byte_t       b;
    int unsigned payload;
    x = XOR_INIT;
    s = '0;
    send_byte(sync_cfg);
    send_byte(byte_t'(len >> 8));
    send_byte(byte_t'(len));
    if (len + 2 < int'(MIN_TOTAL)) return;
    send_byte(byte_t'($urandom_range(255)));
    payload = len - 4;
    if (kind == FRAME_CUT) payload = $urandom_range(payload);
    for (int unsigned k = 0; k < payload; k++) begin
      b = byte_t'($urandom_range(255));
      x = x ^ b;
      s = s + b;
      send_byte(b);
    end
    if (kind == FRAME_CUT) return;
    send_byte(kind == FRAME_BAD_XOR ? x ^ byte_t'($urandom_range(1, 255)) : x);
    send_byte(kind == FRAME_BAD_SUM ? (s + x) ^ byte_t'($urandom_range(1, 255)) : s + x);
  endtask

  task automatic write_sync(input byte_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SYNC_ADDR;
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sync_cfg = v;
    @(posedge clk);
  endtask

  task automatic read_sync();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SYNC_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== sync_cfg)
      flag_error($sformatf("sync register read %h, written %h", prdata[7:0], sync_cfg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned len;
    byte_t       b;
    pick = $urandom_range(99);
    len = ($urandom_range(99) < 85) ? $urandom_range(4, 24) : $urandom_range(25, 260);
    if (pick < 60) begin
      send_frame(len, FRAME_GOOD);
    end else if (pick < 75) begin
      send_frame(len, $urandom_range(1) ? FRAME_BAD_XOR : FRAME_BAD_SUM);
    end else if (pick < 84) begin
      send_frame($urandom_range(3), FRAME_GOOD);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) begin
        b = byte_t'($urandom_range(255));
        send_byte(b == sync_cfg ? ~b : b);
      end
    end else begin
      send_frame($urandom_range(4, 40), FRAME_CUT);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("unexpected result, byte %h position %0d", got.data, got.pos));
      return;
    end
    want = pending_results.pop_front();
    if (got.data !== want.data)
      flag_error($sformatf("data_byte %h, expected %h", got.data, want.data));
    if (got.pos !== want.pos)
      flag_error($sformatf("byte_position %0d, expected %0d", got.pos, want.pos));
    if (got.fin !== want.fin)
      flag_error($sformatf("frame_end %b, expected %b", got.fin, want.fin));
    if (got.verdict !== want.verdict)
      flag_error($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
    if (got.status !== want.status)
      flag_error($sformatf("status_code %h, expected %h", got.status, want.status));
  endtask

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      check_result('{res.data_byte, res.byte_position, res.frame_end, res.verdict,
                     res.status_code});
  end

  // Result side: random back-pressure outside steady phases, plus one long hold-off on each request.
  initial begin
    int hold_left;
    hold_left = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        res.ready <= 1'b0;
      end else begin
        res.ready <= steady || $urandom_range(99) >= 26;
      end
    end
  end

  initial begin
    result_t predicted;
    byte_t   phase_sync;
    int      phase_start;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    errors       = 0;
    sent_bytes   = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    sync_cfg     = SYNC_RESET;
    clear_frame();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    read_sync();

    foreach (DIRECTED[i]) begin
      offer_byte(DIRECTED[i].value, predicted);
      queue_result(DIRECTED[i].typed ? DIRECTED[i].want : predicted);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_sync = 8'h00;
        1: phase_sync = 8'hFF;
        2: phase_sync = SYNC_RESET;
        default: phase_sync = byte_t'($urandom_range(255));
      endcase
      drain();
      write_sync(phase_sync);
      read_sync();
      steady = (p == 2);
      if (p == 1 || p == 4) hold_request = 1'b1;
      phase_start = sent_bytes;
      while (sent_bytes < phase_start + PHASE_BYTES) send_random_unit();
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
